### rtl/core/rgbmd_pkg.sv
package rgbmd_pkg;

  localparam int MaxLineWidth = 4096;
  localparam int ColW = 12;
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegDitherOn     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegBytesPerPix  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegLineWidth    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegThrEvenEven  = 4'd3;
  localparam logic [CfgIdxW-1:0] RegThrEvenOdd   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegThrOddEven   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegThrOddOdd    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegThrPlain     = 4'd7;

  // Luma weights 0.299/31, 0.587/63 and 0.114/31 in Q0.16.
  localparam logic [9:0] CoefR = 10'd632;
  localparam logic [9:0] CoefG = 10'd611;
  localparam logic [9:0] CoefB = 10'd241;

  localparam logic [15:0] SpecialA = 16'h0540;
  localparam logic [15:0] SpecialB = 16'h52bf;

  localparam logic [2:0]      RstBytesPerPix = 3'd2;
  localparam logic [ColW-1:0] RstLineWidth   = 12'd256;
  localparam logic [15:0]     RstThrEvenEven = 16'd43975;
  localparam logic [15:0]     RstThrEvenOdd  = 16'd13271;
  localparam logic [15:0]     RstThrOddEven  = 16'd5059;
  localparam logic [15:0]     RstThrOddOdd   = 16'd25644;
  localparam logic [15:0]     RstThrPlain    = 16'd43909;

  typedef struct packed {
    logic            dither_on;
    logic [2:0]      bytes_per_pixel;
    logic [ColW-1:0] line_width;
    logic [15:0]     thr_even_even;
    logic [15:0]     thr_even_odd;
    logic [15:0]     thr_odd_even;
    logic [15:0]     thr_odd_odd;
    logic [15:0]     thr_plain;
  } cfg_t;

  typedef struct packed {
    logic row_odd;
    logic idx_odd;
  } pos_t;

endpackage

### rtl/core/rgbmd_calc.sv
module rgbmd_calc (
  input  logic [31:0]         pixel_word,
  input  rgbmd_pkg::pos_t     pos,
  input  rgbmd_pkg::cfg_t     cfg,
  output logic [7:0]          mono_value
);

  logic [4:0]  r;
  logic [5:0]  g;
  logic [4:0]  b;
  logic [16:0] luma;
  logic [15:0] thr;
  logic        special;
  logic        bit_on;

  assign r = pixel_word[15:11];
  assign g = pixel_word[10:5];
  assign b = pixel_word[4:0];

  // The sum can exceed 16 bits by a little; comparing at 17 bits gives the
  // same answer as saturating first, since every threshold fits in 16 bits.
  assign luma = 17'(r) * 17'(rgbmd_pkg::CoefR)
              + 17'(g) * 17'(rgbmd_pkg::CoefG)
              + 17'(b) * 17'(rgbmd_pkg::CoefB);

  always_comb begin
    if (cfg.dither_on) begin
      if (!pos.row_odd) begin
        thr = pos.idx_odd ? cfg.thr_even_odd : cfg.thr_even_even;
      end else begin
        thr = pos.idx_odd ? cfg.thr_odd_odd : cfg.thr_odd_even;
      end
      special = 1'b0;
    end else begin
      thr = cfg.thr_plain;
      special = (pixel_word[15:0] == rgbmd_pkg::SpecialA) ||
                (pixel_word[15:0] == rgbmd_pkg::SpecialB);
    end
  end

  assign bit_on = (luma >= 17'(thr)) || special;

  always_comb begin
    case (cfg.bytes_per_pixel)
      3'd0, 3'd1: mono_value = pixel_word[7:0];
      3'd2:       mono_value = {7'd0, bit_on};
      3'd3:       mono_value = pixel_word[7:0] | pixel_word[15:8] | pixel_word[23:16];
      default:    mono_value = pixel_word[7:0] | pixel_word[15:8] |
                               pixel_word[23:16] | pixel_word[31:24];
    endcase
  end

endmodule

### rtl/core/rgb565_to_mono_ordered_dither.sv
// An accepted pixel is held in the input register; its result is computed
// combinationally from there and then registered in the result register.
// Throughput: one pixel per cycle; the input register and the result register
// form a two-stage pipeline that advances whenever the result register is empty
// or its result is taken.
// Reset (rst, synchronous, active high) empties both stages, clears the line
// and frame position, and loads every configuration register with its default.
module rgb565_to_mono_ordered_dither (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     pixel_word,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      mono_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbmd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rgbmd_pkg::CfgDataW-1:0]  cfg_data
);

  rgbmd_pkg::cfg_t cfg;

  logic [rgbmd_pkg::ColW-1:0] column_count;
  logic                       row_is_odd;
  logic                       index_is_odd;

  logic                       s1_valid;
  logic [31:0]                s1_pixel;
  rgbmd_pkg::pos_t            s1_pos;
  logic [7:0]                 s1_result;

  logic                       in_fire;
  logic                       s2_take;

  logic [rgbmd_pkg::ColW-1:0] col_cur;
  logic                       row_cur;
  logic                       idx_cur;
  logic [rgbmd_pkg::ColW:0]   col_inc;
  logic [rgbmd_pkg::ColW:0]   width_eff;
  logic                       line_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dither_on       <= 1'b1;
      cfg.bytes_per_pixel <= rgbmd_pkg::RstBytesPerPix;
      cfg.line_width      <= rgbmd_pkg::RstLineWidth;
      cfg.thr_even_even   <= rgbmd_pkg::RstThrEvenEven;
      cfg.thr_even_odd    <= rgbmd_pkg::RstThrEvenOdd;
      cfg.thr_odd_even    <= rgbmd_pkg::RstThrOddEven;
      cfg.thr_odd_odd     <= rgbmd_pkg::RstThrOddOdd;
      cfg.thr_plain       <= rgbmd_pkg::RstThrPlain;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rgbmd_pkg::RegDitherOn:    cfg.dither_on       <= cfg_data[0];
        rgbmd_pkg::RegBytesPerPix: cfg.bytes_per_pixel <= cfg_data[2:0];
        rgbmd_pkg::RegLineWidth:   cfg.line_width      <= cfg_data[rgbmd_pkg::ColW-1:0];
        rgbmd_pkg::RegThrEvenEven: cfg.thr_even_even   <= cfg_data;
        rgbmd_pkg::RegThrEvenOdd:  cfg.thr_even_odd    <= cfg_data;
        rgbmd_pkg::RegThrOddEven:  cfg.thr_odd_even    <= cfg_data;
        rgbmd_pkg::RegThrOddOdd:   cfg.thr_odd_odd     <= cfg_data;
        rgbmd_pkg::RegThrPlain:    cfg.thr_plain       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_take  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_take;
  assign in_fire  = in_valid && in_ready;

  // A frame start clears the position before the current pixel uses it.
  assign col_cur = frame_start ? '0 : column_count;
  assign row_cur = frame_start ? 1'b0 : row_is_odd;
  assign idx_cur = frame_start ? 1'b0 : index_is_odd;

  assign col_inc   = {1'b0, col_cur} + 1'b1;
  assign width_eff = (cfg.line_width == '0) ? 13'd1 : {1'b0, cfg.line_width};
  assign line_end  = (col_inc >= width_eff) ||
                     (col_inc >= 13'(rgbmd_pkg::MaxLineWidth));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_is_odd   <= 1'b0;
      index_is_odd <= 1'b0;
    end else if (in_fire) begin
      column_count <= line_end ? '0 : col_inc[rgbmd_pkg::ColW-1:0];
      row_is_odd   <= line_end ? !row_cur : row_cur;
      index_is_odd <= !idx_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel       <= pixel_word;
      s1_pos.row_odd <= row_cur;
      s1_pos.idx_odd <= idx_cur;
    end
  end

  rgbmd_calc u_calc (
    .pixel_word (s1_pixel),
    .pos        (s1_pos),
    .cfg        (cfg),
    .mono_value (s1_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      mono_value <= s1_result;
    end
  end

endmodule

### rtl/core/rgbmd_checker.sv
module rgbmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] mono_value,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A stalled result keeps its value until the transaction completes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mono_value))
    else $error("result changed while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side drained, the input side is never held off.
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled while the pipeline can drain");

  // An accepted pixel moves from the input register into the result register,
  // setting out_valid, when out_ready lets any waiting result be taken meanwhile.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted pixel produced no result");

  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind rgb565_to_mono_ordered_dither rgbmd_checker u_rgbmd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .mono_value (mono_value),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
